### design/base64_stream_decoder_macros.svh
// ----------------------------------------------------------------------------
// base64_stream_decoder_macros
// Assertion macros shared by the base64 stream decoder.
// ----------------------------------------------------------------------------
`ifndef BASE64_STREAM_DECODER_MACROS_SVH
`define BASE64_STREAM_DECODER_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge out of reset
`define B64D_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("b64d assertion failed");

// Next-cycle implication, checked on every rising clock edge out of reset
`define B64D_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("b64d assertion failed");

`endif

### design/b64d_pkg.sv
// ----------------------------------------------------------------------------
// b64d_pkg
// Types and constants of the base64 stream decoder.
// ----------------------------------------------------------------------------
package b64d_pkg;

    // The pad character code and the marker for a character outside the alphabet
    localparam logic [7:0] PAD_CHAR   = 8'h3D;
    localparam logic [6:0] BAD_SEXTET = 7'd77;

    // Result status codes
    localparam logic [1:0] STATUS_OK         = 2'd0;
    localparam logic [1:0] STATUS_BAD_CHAR   = 2'd1;
    localparam logic [1:0] STATUS_SHORT_TAIL = 2'd2;

    // Configuration register addresses
    localparam int unsigned CFG_ADDR_W = 2;
    localparam logic [CFG_ADDR_W-1:0] ADDR_URL_ALPHABET = 2'd0;

    // Queue between front and back
    localparam int unsigned Q_DEPTH = 4;
    localparam int unsigned Q_PTR_W = $clog2(Q_DEPTH);

    // One result item
    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_valid;
        logic       last_result;
        logic [1:0] status;
    } result_t;

    // All results caused by one input item
    typedef struct packed {
        logic [1:0]        count;
        result_t [2:0]     res;
    } bundle_t;

    // Write side of the queue
    typedef struct packed {
        logic    valid;
        bundle_t bundle;
    } q_push_t;

    // Read side of the queue
    typedef struct packed {
        logic    valid;
        logic    full;
        bundle_t bundle;
    } q_head_t;

endpackage

### design/b64d_in_if.sv
// ----------------------------------------------------------------------------
// b64d_in_if
// Character channel: one encoded character per item.
// ----------------------------------------------------------------------------
interface b64d_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       end_of_message;

    modport source (output valid, output char_code, output end_of_message, input ready);
    modport sink   (input valid, input char_code, input end_of_message, output ready);
endinterface

### design/b64d_out_if.sv
// ----------------------------------------------------------------------------
// b64d_out_if
// Result channel: one decoded byte or status per item.
// ----------------------------------------------------------------------------
interface b64d_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       last_result;
    logic [1:0] status;

    modport source (output valid, output data_byte, output byte_valid,
                    output last_result, output status, input ready);
    modport sink   (input valid, input data_byte, input byte_valid,
                    input last_result, input status, output ready);
endinterface

### design/base64_stream_decoder.sv
// ----------------------------------------------------------------------------
// base64_stream_decoder
// Streaming base64 decoder, one encoded character per item.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one character and an end-of-message flag per item; out_ch
//   carries one decoded byte or a status-only item per result, the final
//   result of each message marked with last_result. A bad character gives
//   status 1 and a one-character tail status 2; bytes already sent before an
//   error must be dropped downstream. The rest of the message after the
//   first pad or an error is consumed without results, but for its closing result.
//   The APB port holds url_alphabet at address 0 (reset 1, URL-safe).
//   Throughput: one character per cycle while the queue has room. A character is
//   classified in the front and queued as a bundle of up to three results at the edge
//   that accepts it; its first result passes from the queue through the output
//   register onto out_ch. The back drives one result per cycle while out_ch is
//   ready, so a full group of four characters leaves as three bytes in turn.
//   When the receiver stalls, the result holds in the output register; the
//   four-bundle queue fills and then in_ch.ready drops until room returns.
//   Reset empties the queue, clears the group state and selects URL-safe.
// ----------------------------------------------------------------------------
`include "base64_stream_decoder_macros.svh"

module base64_stream_decoder
    import b64d_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready,
    b64d_in_if.sink               in_ch,
    b64d_out_if.source            out_ch
);

    logic    url_reg;
    q_push_t q_push;
    q_head_t q_head;
    logic    pop;

    // Configuration register
    assign pready = 1'b1;
    assign prdata = {31'd0, url_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            url_reg <= 1'b1;
        else if (psel && penable && pwrite && paddr == ADDR_URL_ALPHABET)
            url_reg <= pwdata[0];
    end

    b64d_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_ch        (in_ch),
        .url_alphabet (url_reg),
        .q_head       (q_head),
        .q_push       (q_push)
    );

    b64d_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .q_push (q_push),
        .pop    (pop),
        .q_head (q_head)
    );

    b64d_back u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .q_head (q_head),
        .pop    (pop),
        .out_ch (out_ch)
    );

    // Never push into a full queue
    `B64D_ASSERT_NOW(a_no_push_full, q_push.valid, !q_head.full)
    // Every accepted end of message produces a bundle
    `B64D_ASSERT_NOW(a_eom_pushes, in_ch.valid && in_ch.ready && in_ch.end_of_message, q_push.valid)
    // Queued bundles are never empty
    `B64D_ASSERT_NOW(a_head_nonempty, q_head.valid, q_head.bundle.count != 2'd0)
    // A push makes the queue non-empty in the next cycle
    `B64D_ASSERT_NEXT(a_push_visible, q_push.valid, q_head.valid)

endmodule

### design/b64d_front.sv
// ----------------------------------------------------------------------------
// b64d_front
// Accepts characters, maps them to sextets, tracks the group and the decode
// mode, and pushes the results of each character as one bundle.
// ----------------------------------------------------------------------------
module b64d_front
    import b64d_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    b64d_in_if.sink      in_ch,
    input  logic         url_alphabet,
    input  q_head_t      q_head,
    output q_push_t      q_push
);

    typedef enum logic [3:0] {
        MODE_DECODE = 4'b0001,
        MODE_PAD    = 4'b0010,
        MODE_BAD    = 4'b0100,
        MODE_SHORT  = 4'b1000
    } mode_t;

    logic [17:0] hold_reg, hold_next;
    logic [1:0]  fill_reg, fill_next;
    mode_t       mode_reg, mode_next;

    logic        accept;
    bundle_t     bundle;

    // Map a character to its 6-bit value, or to the bad marker
    function automatic logic [6:0] char_value(input logic [7:0] c, input logic url);
        logic [6:0] v;
        v = BAD_SEXTET;
        if (c >= 8'h41 && c <= 8'h5A)      v = {1'b0, 6'(c - 8'h41)};
        else if (c >= 8'h61 && c <= 8'h7A) v = {1'b0, 6'(c - 8'h61 + 8'd26)};
        else if (c >= 8'h30 && c <= 8'h39) v = {1'b0, 6'(c - 8'h30 + 8'd52)};
        else if (url && c == 8'h2D)        v = 7'd62;
        else if (url && c == 8'h5F)        v = 7'd63;
        else if (!url && c == 8'h2B)       v = 7'd62;
        else if (!url && c == 8'h2F)       v = 7'd63;
        return v;
    endfunction

    assign in_ch.ready = !q_head.full;
    assign accept      = in_ch.valid && in_ch.ready;

    // Classify the character and build its results
    always_comb
    begin
        logic [6:0]  v;
        logic [23:0] w;
        logic        do_close;
        logic [1:0]  st;

        hold_next  = hold_reg;
        fill_next  = fill_reg;
        mode_next  = mode_reg;
        bundle     = '0;
        do_close   = 1'b0;
        v          = char_value(in_ch.char_code, url_alphabet);
        w          = {hold_reg, v[5:0]};
        st         = STATUS_OK;

        if (mode_reg == MODE_DECODE)
        begin
            if (in_ch.char_code == PAD_CHAR)
            begin
                do_close = 1'b1;
            end
            else
            begin
                if (v == BAD_SEXTET)
                begin
                    bundle.res[0] = '{8'd0, 1'b0, 1'b0, STATUS_BAD_CHAR};
                    bundle.count  = 2'd1;
                    mode_next     = MODE_BAD;
                end
                else if (fill_reg == 2'd3)
                begin
                    bundle.res[0] = '{w[23:16], 1'b1, 1'b0, STATUS_OK};
                    bundle.res[1] = '{w[15:8],  1'b1, 1'b0, STATUS_OK};
                    bundle.res[2] = '{w[7:0],   1'b1, 1'b0, STATUS_OK};
                    bundle.count  = 2'd3;
                    hold_next     = '0;
                    fill_next     = '0;
                end
                else
                begin
                    hold_next = {hold_reg[11:0], v[5:0]};
                    fill_next = fill_reg + 2'd1;
                end
                if (in_ch.end_of_message && mode_next == MODE_DECODE)
                    do_close = 1'b1;
            end
        end

        // Close the tail; no results precede it in this item
        if (do_close)
        begin
            mode_next = MODE_PAD;
            case (fill_next)
                2'd1:
                begin
                    bundle.res[0] = '{8'd0, 1'b0, 1'b0, STATUS_SHORT_TAIL};
                    bundle.count  = 2'd1;
                    mode_next     = MODE_SHORT;
                end
                2'd2:
                begin
                    bundle.res[0] = '{hold_next[11:4], 1'b1, 1'b0, STATUS_OK};
                    bundle.count  = 2'd1;
                end
                2'd3:
                begin
                    bundle.res[0] = '{hold_next[17:10], 1'b1, 1'b0, STATUS_OK};
                    bundle.res[1] = '{hold_next[9:2],   1'b1, 1'b0, STATUS_OK};
                    bundle.count  = 2'd2;
                end
                default: ;
            endcase
            hold_next = '0;
            fill_next = '0;
        end

        // Mark the end of the message and start over
        if (in_ch.end_of_message)
        begin
            case (bundle.count)
                2'd1:    bundle.res[0].last_result = 1'b1;
                2'd2:    bundle.res[1].last_result = 1'b1;
                2'd3:    bundle.res[2].last_result = 1'b1;
                default:
                begin
                    if (mode_next == MODE_BAD)        st = STATUS_BAD_CHAR;
                    else if (mode_next == MODE_SHORT) st = STATUS_SHORT_TAIL;
                    bundle.res[0] = '{8'd0, 1'b0, 1'b1, st};
                    bundle.count  = 2'd1;
                end
            endcase
            hold_next = '0;
            fill_next = '0;
            mode_next = MODE_DECODE;
        end
    end

    assign q_push.valid  = accept && (bundle.count != 2'd0);
    assign q_push.bundle = bundle;

    // Advance the decode state on each accepted character
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_reg <= '0;
            fill_reg <= '0;
            mode_reg <= MODE_DECODE;
        end
        else if (accept)
        begin
            hold_reg <= hold_next;
            fill_reg <= fill_next;
            mode_reg <= mode_next;
        end
    end

endmodule

### design/b64d_queue.sv
// ----------------------------------------------------------------------------
// b64d_queue
// Short queue of result bundles between the front and the back.
// ----------------------------------------------------------------------------
module b64d_queue
    import b64d_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  q_push_t q_push,
    input  logic    pop,
    output q_head_t q_head
);

    bundle_t             mem [Q_DEPTH];
    logic [Q_PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [Q_PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [Q_PTR_W:0]    count_reg, count_next;

    assign q_head.valid  = (count_reg != '0);
    assign q_head.full   = (count_reg == (Q_PTR_W+1)'(Q_DEPTH));
    assign q_head.bundle = mem[rd_ptr_reg];

    // Move the pointers and the fill count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (q_push.valid)
            wr_ptr_next = wr_ptr_reg + Q_PTR_W'(1);
        if (pop)
            rd_ptr_next = rd_ptr_reg + Q_PTR_W'(1);
        if (q_push.valid && !pop)
            count_next = count_reg + (Q_PTR_W+1)'(1);
        else if (!q_push.valid && pop)
            count_next = count_reg - (Q_PTR_W+1)'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store a pushed bundle
    always_ff @(posedge clk)
    begin
        if (q_push.valid)
            mem[wr_ptr_reg] <= q_push.bundle;
    end

endmodule

### design/b64d_back.sv
// ----------------------------------------------------------------------------
// b64d_back
// Unpacks queued bundles into single result items through an output
// register.
// ----------------------------------------------------------------------------
module b64d_back
    import b64d_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  q_head_t      q_head,
    output logic         pop,
    b64d_out_if.source   out_ch
);

    logic       out_valid_reg, out_valid_next;
    result_t    out_res_reg;
    logic [1:0] sel_reg, sel_next;
    logic       load;
    logic       at_end;
    result_t    cur;

    assign load   = q_head.valid && (!out_valid_reg || out_ch.ready);
    assign at_end = (sel_reg == q_head.bundle.count - 2'd1);
    assign pop    = load && at_end;

    // Pick the result under the cursor
    always_comb
    begin
        case (sel_reg)
            2'd1:    cur = q_head.bundle.res[1];
            2'd2:    cur = q_head.bundle.res[2];
            default: cur = q_head.bundle.res[0];
        endcase
    end

    // Advance the cursor and the output valid
    always_comb
    begin
        sel_next       = sel_reg;
        out_valid_next = out_valid_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
            sel_next       = at_end ? 2'd0 : sel_reg + 2'd1;
        end
        else if (out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            sel_reg       <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            sel_reg       <= sel_next;
        end
    end

    // Hold the result until it is taken
    always_ff @(posedge clk)
    begin
        if (load)
            out_res_reg <= cur;
    end

    assign out_ch.valid       = out_valid_reg;
    assign out_ch.data_byte   = out_res_reg.data_byte;
    assign out_ch.byte_valid  = out_res_reg.byte_valid;
    assign out_ch.last_result = out_res_reg.last_result;
    assign out_ch.status      = out_res_reg.status;

endmodule

### sim/tb_base64_stream_decoder.sv
// ----------------------------------------------------------------------------
// tb_base64_stream_decoder
// Self-checking bench for the streaming base64 decoder.
// ----------------------------------------------------------------------------
// Feeds encoded characters over in_ch and checks every item on out_ch
// against a decoder model kept inside the bench. The model follows the
// alphabet register, the four-character groups, the pad and error stops
// and the closing result of each message. A directed set of messages
// comes first. Random messages follow in phases that differ in sender
// gaps, receiver stalls and alphabet. One phase holds the receiver off
// long enough to back up the block and stall its input.
// ----------------------------------------------------------------------------
module tb_base64_stream_decoder;
    import b64d_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned CYCLE_LIMIT  = 200000;
    localparam int unsigned DRAIN_CYCLES = 12;
    localparam int unsigned HOLD_CYCLES  = 80;

    // Decoder state of the bench model
    typedef enum logic [1:0] {
        DECODING  = 2'd0,
        PAD_SEEN  = 2'd1,
        BAD_STOP  = 2'd2,
        TAIL_STOP = 2'd3
    } decode_mode_t;

    // One character as it goes onto in_ch
    typedef struct {
        logic [7:0] ch;
        bit         eom;
    } char_item_t;

    // ------------------------------------------------------------------------
    // Decoder model and store of expected results
    // ------------------------------------------------------------------------
    class b64_decode_board;
        bit           url_alphabet;
        logic [17:0]  pending_bits;
        logic [1:0]   pending_count;
        decode_mode_t mode;
        result_t      step_results[$];
        result_t      expected_results[$];
        int unsigned  fails;

        function void clear_state();
            pending_bits  = '0;
            pending_count = '0;
            mode          = DECODING;
        endfunction

        function void reset_all();
            url_alphabet = 1'b1;
            clear_state();
            expected_results.delete();
            fails = 0;
        endfunction

        function int pending();
            return expected_results.size();
        endfunction

        function result_t make_result(logic [7:0] b, logic bv, logic [1:0] st);
            result_t r;
            r.data_byte   = b;
            r.byte_valid  = bv;
            r.last_result = 1'b0;
            r.status      = st;
            return r;
        endfunction

        // Map a character to its 6-bit value, BAD_SEXTET when outside
        function logic [6:0] sextet_of(logic [7:0] c);
            if (c >= "A" && c <= "Z") return 7'(c - "A");
            if (c >= "a" && c <= "z") return 7'(c - "a" + 26);
            if (c >= "0" && c <= "9") return 7'(c - "0" + 52);
            if (url_alphabet)
            begin
                if (c == "-") return 7'd62;
                if (c == "_") return 7'd63;
            end
            else
            begin
                if (c == "+") return 7'd62;
                if (c == "/") return 7'd63;
            end
            return BAD_SEXTET;
        endfunction

        // Close a partial group: one value is an error, two or three give bytes, none gives nothing
        function void flush_tail();
            if (pending_count == 2'd1)
            begin
                step_results.push_back(make_result(8'h00, 1'b0, STATUS_SHORT_TAIL));
                mode = TAIL_STOP;
            end
            else
            begin
                if (pending_count == 2'd2)
                    step_results.push_back(make_result(pending_bits[11:4], 1'b1, STATUS_OK));
                else if (pending_count == 2'd3)
                begin
                    step_results.push_back(make_result(pending_bits[17:10], 1'b1, STATUS_OK));
                    step_results.push_back(make_result(pending_bits[9:2], 1'b1, STATUS_OK));
                end
                mode = PAD_SEEN;
            end
            pending_bits  = '0;
            pending_count = '0;
        endfunction

        // Predict the results of one accepted character
        function void note_char(logic [7:0] c, bit eom);
            logic [6:0]  v;
            logic [23:0] word;
            logic [1:0]  st;
            result_t     r;
            step_results.delete();
            if (mode == DECODING)
            begin
                if (c == PAD_CHAR)
                    flush_tail();
                else
                begin
                    v = sextet_of(c);
                    if (v == BAD_SEXTET)
                    begin
                        step_results.push_back(make_result(8'h00, 1'b0, STATUS_BAD_CHAR));
                        mode = BAD_STOP;
                    end
                    else if (pending_count == 2'd3)
                    begin
                        word = {pending_bits, v[5:0]};
                        step_results.push_back(make_result(word[23:16], 1'b1, STATUS_OK));
                        step_results.push_back(make_result(word[15:8], 1'b1, STATUS_OK));
                        step_results.push_back(make_result(word[7:0], 1'b1, STATUS_OK));
                        pending_bits  = '0;
                        pending_count = '0;
                    end
                    else
                    begin
                        pending_bits  = {pending_bits[11:0], v[5:0]};
                        pending_count = pending_count + 2'd1;
                    end
                    if (eom && mode == DECODING)
                        flush_tail();
                end
            end
            // Mark the last result of the message, or add a closing one
            if (eom)
            begin
                if (step_results.size() > 0)
                begin
                    r = step_results[step_results.size() - 1];
                    r.last_result = 1'b1;
                    step_results[step_results.size() - 1] = r;
                end
                else
                begin
                    st = (mode == BAD_STOP)  ? STATUS_BAD_CHAR :
                         (mode == TAIL_STOP) ? STATUS_SHORT_TAIL : STATUS_OK;
                    r = make_result(8'h00, 1'b0, st);
                    r.last_result = 1'b1;
                    step_results.push_back(r);
                end
                clear_state();
            end
            foreach (step_results[i])
                expected_results.push_back(step_results[i]);
        endfunction

        // Compare one accepted result with the oldest expectation
        function void check_result(result_t got);
            result_t want;
            if (expected_results.size() == 0)
            begin
                $display("%0t: unexpected result byte=%h bv=%b last=%b st=%0d", $time,
                         got.data_byte, got.byte_valid, got.last_result, got.status);
                fails++;
                return;
            end
            want = expected_results.pop_front();
            if (got.data_byte !== want.data_byte)
            begin
                $display("%0t: data_byte expected %h actual %h", $time,
                         want.data_byte, got.data_byte);
                fails++;
            end
            if (got.byte_valid !== want.byte_valid)
            begin
                $display("%0t: byte_valid expected %b actual %b", $time,
                         want.byte_valid, got.byte_valid);
                fails++;
            end
            if (got.last_result !== want.last_result)
            begin
                $display("%0t: last_result expected %b actual %b", $time,
                         want.last_result, got.last_result);
                fails++;
            end
            if (got.status !== want.status)
            begin
                $display("%0t: status expected %0d actual %0d", $time,
                         want.status, got.status);
                fails++;
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Signals, block instance
    // ------------------------------------------------------------------------
    logic                  clk;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [31:0]           pwdata;
    logic [31:0]           prdata;
    logic                  pready;

    b64d_in_if  in_ch();
    b64d_out_if out_ch();

    base64_stream_decoder dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .in_ch   (in_ch),
        .out_ch  (out_ch)
    );

    b64_decode_board board;
    char_item_t      char_stream[$];
    int unsigned     gap_pct;
    int unsigned     stall_pct;
    bit              hold_active;
    int unsigned     cycle_count = 0;
    event            hold_ev;

    // Free-running clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Receiver: stall at random, or hold off completely during a long hold
    initial
    begin
        out_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            out_ch.ready = !hold_active && ($urandom_range(0, 99) >= stall_pct);
        end
    end

    // Long hold-off, counted here so the sender keeps offering items
    initial
    begin
        hold_active = 1'b0;
        forever
        begin
            @(hold_ev);
            @(posedge clk);
            hold_active = 1'b1;
            repeat (HOLD_CYCLES) @(posedge clk);
            hold_active = 1'b0;
        end
    end

    // Check every accepted result
    always @(posedge clk)
    begin
        if (rst_n && out_ch.valid === 1'b1 && out_ch.ready)
            board.check_result('{data_byte:   out_ch.data_byte,
                                 byte_valid:  out_ch.byte_valid,
                                 last_result: out_ch.last_result,
                                 status:      out_ch.status});
    end

    // ------------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------------

    // Write url_alphabet over APB, then read it back; called at a falling edge
    task automatic set_alphabet(bit url);
        psel    = 1'b1;
        pwrite  = 1'b1;
        penable = 1'b0;
        paddr   = ADDR_URL_ALPHABET;
        pwdata  = {31'b0, url};
        @(negedge clk);
        penable = 1'b1;
        do @(posedge clk); while (!pready);
        board.url_alphabet = url;
        @(negedge clk);
        pwrite  = 1'b0;
        penable = 1'b0;
        @(negedge clk);
        penable = 1'b1;
        do @(posedge clk); while (!pready);
        if (prdata !== {31'b0, url})
        begin
            $display("%0t: url_alphabet read expected %h actual %h", $time,
                     {31'b0, url}, prdata);
            board.fails++;
        end
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    // Offer one character and hold it until accepted; called at a falling edge
    task automatic send_char(char_item_t it);
        while ($urandom_range(0, 99) < gap_pct)
        begin
            in_ch.valid = 1'b0;
            @(negedge clk);
        end
        in_ch.valid          = 1'b1;
        in_ch.char_code      = it.ch;
        in_ch.end_of_message = it.eom;
        do @(posedge clk); while (!in_ch.ready);
        board.note_char(it.ch, it.eom);
        @(negedge clk);
    endtask

    function automatic logic [7:0] sextet_char(int unsigned v, bit url);
        if (v < 26) return 8'("A" + v);
        if (v < 52) return 8'("a" + v - 26);
        if (v < 62) return 8'("0" + v - 52);
        if (v == 62) return url ? 8'("-") : 8'("+");
        return url ? 8'("_") : 8'("/");
    endfunction

    function automatic void push_char(logic [7:0] c);
        char_item_t it;
        it.ch  = c;
        it.eom = 1'b0;
        char_stream.push_back(it);
    endfunction

    // Mark the newest queued character as the end of its message
    function automatic void close_message();
        char_item_t it;
        it = char_stream[char_stream.size() - 1];
        it.eom = 1'b1;
        char_stream[char_stream.size() - 1] = it;
    endfunction

    function automatic void push_text(string s);
        for (int i = 0; i < s.len(); i++)
            push_char(s[i]);
        close_message();
    endfunction

    // Queue one random message: mostly well-formed, the rest noise
    function automatic void make_message();
        int unsigned n_sym;
        bit          url;
        if ($urandom_range(0, 99) < 75)
        begin
            n_sym = ($urandom_range(0, 9) == 0) ? 1 : $urandom_range(2, 12);
            url   = board.url_alphabet ^ ($urandom_range(0, 19) == 0);
            for (int i = 0; i < n_sym; i++)
                push_char(sextet_char($urandom_range(0, 63), url));
            if ($urandom_range(0, 1) == 1)
            begin
                push_char(PAD_CHAR);
                for (int i = n_sym + 1; i % 4 != 0; i++)
                    push_char(PAD_CHAR);
            end
            if ($urandom_range(0, 3) == 0)
                for (int i = $urandom_range(1, 3); i > 0; i--)
                    push_char(8'($urandom_range(0, 255)));
        end
        else
        begin
            for (int i = $urandom_range(1, 6); i > 0; i--)
            begin
                if ($urandom_range(0, 1) == 1)
                    push_char(8'($urandom_range(0, 255)));
                else if ($urandom_range(0, 4) == 0)
                    push_char(PAD_CHAR);
                else
                    push_char(sextet_char($urandom_range(0, 63), $urandom_range(0, 1)));
            end
        end
        close_message();
    endfunction

    // Send n characters from the stream, refilling it with random messages
    task automatic run_chars(int unsigned n);
        repeat (n)
        begin
            if (char_stream.size() == 0)
                make_message();
            send_char(char_stream.pop_front());
        end
        in_ch.valid = 1'b0;
    endtask

    // Wait for every expected result plus the block's own latency
    task automatic settle();
        while (board.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        @(negedge clk);
    endtask

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial
    begin
        board = new();
        board.reset_all();
        gap_pct              = 0;
        stall_pct            = 0;
        rst_n                = 1'b0;
        psel                 = 1'b0;
        penable              = 1'b0;
        pwrite               = 1'b0;
        paddr                = '0;
        pwdata               = '0;
        in_ch.valid          = 1'b0;
        in_ch.char_code      = '0;
        in_ch.end_of_message = 1'b0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed messages on the reset alphabet (URL-safe)
        push_text("AZaz09-_");     // full groups, alphabet extremes
        push_text("Q");            // one-character tail
        push_text("QQ==");         // pad after two values, second pad ignored
        push_text("A+B");          // bad character, rest ignored
        push_text("=");            // pad with nothing pending
        push_text("QUJ");          // unpadded three-value tail
        push_text("Q=x");          // pad after a single value
        push_char(8'hFF);
        close_message();
        push_char(8'h00);
        close_message();
        run_chars(char_stream.size());
        settle();

        // No idling, standard alphabet
        set_alphabet(1'b0);
        run_chars(70);
        settle();

        // Sender mostly idle, URL-safe
        set_alphabet(1'b1);
        gap_pct = 82;
        run_chars(70);
        settle();

        // Receiver mostly stalled, standard alphabet
        set_alphabet(1'b0);
        gap_pct   = 0;
        stall_pct = 82;
        run_chars(70);
        settle();

        // Both sides idle now and then, URL-safe
        set_alphabet(1'b1);
        gap_pct   = 20;
        stall_pct = 20;
        run_chars(70);
        settle();

        // Long receiver hold-off while characters keep coming
        set_alphabet(1'b0);
        gap_pct   = 0;
        stall_pct = 0;
        -> hold_ev;
        run_chars(70);
        settle();

        if (board.fails == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
